/* rtl/weighted_record_shaping_selector_assert.svh */
// Assertion macros shared by the checker of the weighted record shaping selector.
// Depends on nothing; included by the checker file only.
`ifndef WEIGHTED_RECORD_SHAPING_SELECTOR_ASSERT_SVH
`define WEIGHTED_RECORD_SHAPING_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define WRSS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WRSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wrss_pkg.sv */
// Shared types, request codes and sizes for the weighted record shaping selector.
// No dependencies; imported by the controller, the datapath and the top level.
package wrss_pkg;

  // Outcome table depth and the widths that follow from it.
  localparam int MAX_OUTCOMES = 8;
  localparam int IDX_W = (MAX_OUTCOMES > 1) ? $clog2(MAX_OUTCOMES) : 1;
  localparam int CNT_W = $clog2(MAX_OUTCOMES + 1);
  localparam int SUM_W = $clog2(MAX_OUTCOMES * 127 + 1);

  // Largest valid percent roll.
  localparam int PCT_MAX = 100;

  // Port widths.
  localparam int S_TDATA_W   = 232;
  localparam int S_TUSER_W   = 3;
  localparam int M_TDATA_W   = 264;
  localparam int M_TUSER_W   = 1;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Request codes.
  localparam logic [2:0] REQ_DECIDE    = 3'd0;
  localparam logic [2:0] REQ_STATS     = 3'd1;
  localparam logic [2:0] REQ_WEIGHT    = 3'd2;
  localparam logic [2:0] REQ_PAD_RANGE = 3'd3;
  localparam logic [2:0] REQ_DLY_RANGE = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNT  = 2'd2;

  // One input item, unpacked.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [6:0]  pick_pct;
    logic [6:0]  dly_pct;
    logic [31:0] pad_raw;
    logic [31:0] dly_raw;
    logic [31:0] requested_padding;
    logic [31:0] effective_padding;
    logic [2:0]  entry_index;
    logic [6:0]  entry_weight;
    logic [1:0]  entry_enables;
    logic [6:0]  entry_delay_chance;
    logic [63:0] range_bounds;
  } item_t;

  // One result item, unpacked.
  typedef struct packed {
    logic        accepted;
    logic        considered;
    logic        entry_hit;
    logic [2:0]  entry_sel;
    logic [31:0] padding_bytes_out;
    logic [31:0] delay_ms_out;
    logic [31:0] records_seen_count;
    logic [31:0] records_delayed_count;
    logic [31:0] records_padded_count;
    logic [47:0] requested_bytes_total;
    logic [47:0] effective_bytes_total;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic clamp;
    logic emit;
  } wrss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk;
    logic hit;
    logic last;
    logic out_free;
  } wrss_sts_t;

endpackage

/* rtl/wrss_ctrl.sv */
// Controller state machine of the weighted record shaping selector.
// Depends on wrss_pkg; drives commands into wrss_datapath.
module wrss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wrss_pkg::wrss_sts_t sts,
  output wrss_pkg::wrss_cmd_t cmd
);
  import wrss_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    WALK,
    CLAMP,
    DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and the commands issued in each state.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.walk ? WALK : DONE;
      end
      WALK: begin
        cmd.step = 1'b1;
        if (sts.hit) begin
          state_next = CLAMP;
        end else if (sts.last) begin
          state_next = DONE;
        end
      end
      CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = DONE;
      end
      DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State register and the registered input ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == IDLE);
    end
  end

endmodule

/* rtl/wrss_datapath.sv */
// Datapath of the weighted record shaping selector: configuration, outcome table,
// table walk, clamping, counters and the output register. Depends on wrss_pkg.
module wrss_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wrss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wrss_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wrss_pkg::item_t                     in_item,
  input  wrss_pkg::wrss_cmd_t                 cmd,
  output wrss_pkg::wrss_sts_t                 sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wrss_pkg::result_t                   out_result
);
  import wrss_pkg::*;

  typedef struct packed {
    logic [6:0] chance;
    logic       has_dly;
    logic       has_pad;
    logic [6:0] weight;
  } entry_t;

  // Clamp a draw into [min, max]; below min wins when the range is inverted.
  function automatic logic [31:0] clamp_to(input logic [31:0] v, input logic [63:0] range);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = range[31:0];
    hi = range[63:32];
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Configuration registers.
  logic        enable;
  logic [31:0] limit;
  logic [3:0]  count;

  // Outcome table.
  entry_t      weights    [MAX_OUTCOMES];
  logic [63:0] pad_ranges [MAX_OUTCOMES];
  logic [63:0] dly_ranges [MAX_OUTCOMES];

  // Counters.
  logic [31:0] seen;
  logic [31:0] delayed;
  logic [31:0] padded;
  logic [47:0] req_total;
  logic [47:0] eff_total;

  // Item under work, walk state and decision.
  item_t            item_q;
  logic [IDX_W-1:0] idx;
  logic [SUM_W-1:0] sum;
  logic [IDX_W-1:0] sel;
  logic             res_accepted;
  logic             res_considered;
  logic             res_selected;
  logic [31:0]      res_pad;
  logic [31:0]      res_dly;

  logic [CNT_W-1:0] n_active;
  logic             roll_ok;
  logic             in_window;
  logic             is_decide;
  logic             decide_go;
  logic [SUM_W-1:0] sum_next;
  logic             wr_ok;
  logic [IDX_W-1:0] wr_idx;
  entry_t           sel_entry;
  logic [31:0]      pad_val;
  logic [31:0]      dly_val;

  assign cfg_ready = 1'b1;

  // Decide and table-write checks on the held item.
  always_comb begin
    if (int'(count) > MAX_OUTCOMES) begin
      n_active = CNT_W'(MAX_OUTCOMES);
    end else begin
      n_active = CNT_W'(count);
    end
    roll_ok = enable
           && (item_q.pick_pct >= 7'd1) && (item_q.pick_pct <= 7'(PCT_MAX))
           && (item_q.dly_pct >= 7'd1) && (item_q.dly_pct <= 7'(PCT_MAX));
    in_window = (seen < limit);
    is_decide = (item_q.req_type == REQ_DECIDE);
    decide_go = is_decide && roll_ok && in_window;
    wr_ok     = int'(item_q.entry_index) < MAX_OUTCOMES;
    wr_idx    = IDX_W'(item_q.entry_index);
  end

  // One table entry per step: running weight sum and match test.
  always_comb begin
    sum_next     = sum + SUM_W'(weights[idx].weight);
    sts.walk     = decide_go && (n_active != '0);
    sts.hit      = (SUM_W'(item_q.pick_pct) <= sum_next);
    sts.last     = ((CNT_W'(idx) + CNT_W'(1)) == n_active);
    sts.out_free = !out_valid || out_ready;
  end

  // Clamping of the draws against the matched entry.
  always_comb begin
    sel_entry = weights[sel];
    pad_val   = sel_entry.has_pad ? clamp_to(item_q.pad_raw, pad_ranges[sel]) : 32'd0;
    if (sel_entry.has_dly && (item_q.dly_pct <= sel_entry.chance)) begin
      dly_val = clamp_to(item_q.dly_raw, dly_ranges[sel]);
    end else begin
      dly_val = 32'd0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      limit  <= 32'd0;
      count  <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE: enable <= cfg_data[0];
        CFG_LIMIT:  limit  <= cfg_data;
        CFG_COUNT:  count  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Outcome table writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_OUTCOMES; i++) begin
        weights[i]    <= '0;
        pad_ranges[i] <= '0;
        dly_ranges[i] <= '0;
      end
    end else if (cmd.check && wr_ok) begin
      case (item_q.req_type)
        REQ_WEIGHT: begin
          weights[wr_idx] <= '{chance:  item_q.entry_delay_chance,
                               has_dly: item_q.entry_enables[1],
                               has_pad: item_q.entry_enables[0],
                               weight:  item_q.entry_weight};
        end
        REQ_PAD_RANGE: pad_ranges[wr_idx] <= item_q.range_bounds;
        REQ_DLY_RANGE: dly_ranges[wr_idx] <= item_q.range_bounds;
        default: ;
      endcase
    end
  end

  // Record and padding counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      delayed   <= '0;
      padded    <= '0;
      req_total <= '0;
      eff_total <= '0;
    end else begin
      if (cmd.check && decide_go) begin
        seen <= seen + 32'd1;
      end
      if (cmd.check && (item_q.req_type == REQ_STATS)
          && (item_q.requested_padding != 32'd0)) begin
        if (item_q.effective_padding != 32'd0) begin
          padded <= padded + 32'd1;
        end
        req_total <= req_total + 48'(item_q.requested_padding);
        eff_total <= eff_total + 48'(item_q.effective_padding);
      end
      if (cmd.clamp && (dly_val != 32'd0)) begin
        delayed <= delayed + 32'd1;
      end
    end
  end

  // Item capture, table walk and decision registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q         <= in_item;
      res_accepted   <= 1'b0;
      res_considered <= 1'b0;
      res_selected   <= 1'b0;
      res_pad        <= 32'd0;
      res_dly        <= 32'd0;
      sel            <= '0;
    end
    if (cmd.check) begin
      if (is_decide) begin
        res_accepted <= roll_ok;
      end else begin
        res_accepted <= (item_q.req_type == REQ_STATS) || (item_q.req_type == REQ_WEIGHT)
                     || (item_q.req_type == REQ_PAD_RANGE)
                     || (item_q.req_type == REQ_DLY_RANGE);
      end
      res_considered <= decide_go;
      sum            <= '0;
      idx            <= '0;
    end
    if (cmd.step) begin
      sum <= sum_next;
      idx <= idx + IDX_W'(1);
      if (sts.hit) begin
        res_selected <= 1'b1;
        sel          <= idx;
      end
    end
    if (cmd.clamp) begin
      res_pad <= pad_val;
      res_dly <= dly_val;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload with the counters as they stand after the item.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_result <= '{accepted:              res_accepted,
                      considered:            res_considered,
                      entry_hit:             res_selected,
                      entry_sel:             res_selected ? 3'(sel) : 3'd0,
                      padding_bytes_out:     res_pad,
                      delay_ms_out:          res_dly,
                      records_seen_count:    seen,
                      records_delayed_count: delayed,
                      records_padded_count:  padded,
                      requested_bytes_total: req_total,
                      effective_bytes_total: eff_total};
    end
  end

endmodule

/* rtl/weighted_record_shaping_selector.sv */
// Top level of the weighted record shaping selector: stream ports, field packing,
// controller and datapath. Depends on wrss_pkg, wrss_ctrl and wrss_datapath.
//
// The block handles one item at a time. A decide item that walks the outcome
// table passes through IDLE, CHECK, one WALK step for each table entry walked
// (1 up to the configured entry count, at most 8), CLAMP when an entry matches,
// and DONE; the walk adds one entry per cycle. Statistics, table writes, unknown
// requests and decides that are rejected, outside the window or have no entries
// in use go from CHECK straight to DONE. Each result sits in an output register,
// so a new item is taken while the last result waits; the next result is held
// back only until that register is free. Configuration writes are always ready;
// the user must keep them to idle periods, as the block does not enforce this.
module weighted_record_shaping_selector (
  input  logic                             clk,
  input  logic                             rst,
  // Input item stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: pick_pct, dly_pct, pad_raw, dly_raw,
  // requested_padding, effective_padding, entry_index, entry_weight,
  // entry_enables, entry_delay_chance, range_bounds, zero fill.
  input  logic [wrss_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0 up: req_type.
  input  logic [wrss_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0 up: considered, entry_hit, entry_sel,
  // padding_bytes_out, delay_ms_out, records_seen_count, records_delayed_count,
  // records_padded_count, requested_bytes_total, effective_bytes_total, zero fill.
  output logic [wrss_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // Fields from bit 0 up: accepted.
  output logic [wrss_pkg::M_TUSER_W-1:0]   m_axis_tuser,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wrss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wrss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wrss_pkg::*;

  item_t     in_item;
  result_t   res;
  wrss_cmd_t cmd;
  wrss_sts_t sts;

  // Unpack the input item.
  always_comb begin
    in_item.req_type           = s_axis_tuser[2:0];
    in_item.pick_pct           = s_axis_tdata[6:0];
    in_item.dly_pct            = s_axis_tdata[13:7];
    in_item.pad_raw            = s_axis_tdata[45:14];
    in_item.dly_raw            = s_axis_tdata[77:46];
    in_item.requested_padding  = s_axis_tdata[109:78];
    in_item.effective_padding  = s_axis_tdata[141:110];
    in_item.entry_index        = s_axis_tdata[144:142];
    in_item.entry_weight       = s_axis_tdata[151:145];
    in_item.entry_enables      = s_axis_tdata[153:152];
    in_item.entry_delay_chance = s_axis_tdata[160:154];
    in_item.range_bounds       = s_axis_tdata[224:161];
  end

  // Pack the result item.
  always_comb begin
    m_axis_tuser[0]        = res.accepted;
    m_axis_tdata           = '0;
    m_axis_tdata[0]        = res.considered;
    m_axis_tdata[1]        = res.entry_hit;
    m_axis_tdata[4:2]      = res.entry_sel;
    m_axis_tdata[36:5]     = res.padding_bytes_out;
    m_axis_tdata[68:37]    = res.delay_ms_out;
    m_axis_tdata[100:69]   = res.records_seen_count;
    m_axis_tdata[132:101]  = res.records_delayed_count;
    m_axis_tdata[164:133]  = res.records_padded_count;
    m_axis_tdata[212:165]  = res.requested_bytes_total;
    m_axis_tdata[260:213]  = res.effective_bytes_total;
  end

  // Sequencing of each item.
  wrss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, walk, clamping, counters and output register.
  wrss_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (res)
  );

endmodule

/* rtl/wrss_checker.sv */
// Port-level checker for the weighted record shaping selector, bound to the top.
// Depends on weighted_record_shaping_selector_assert.svh.
`include "weighted_record_shaping_selector_assert.svh"

module wrss_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [263:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  // A stalled result holds.
  `WRSS_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // One item at a time: no item is taken in the cycle after one was taken.
  `WRSS_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item taken back to back")

  // A rejected request carries an all-zero decision.
  `WRSS_ASSERT_IMPL(a_reject_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[68:0] == 69'd0, "rejected item with nonzero decision")

  // A record that is not considered, such as one outside the window, gets no outcome, padding or delay.
  `WRSS_ASSERT_IMPL(a_unconsidered_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[68:1] == 68'd0, "decision without considered record")

endmodule

bind weighted_record_shaping_selector wrss_checker u_wrss_checker (.*);

/* tb/sv/wrss_shaping_checker.sv */
`timescale 1ns / 100ps
// Checker for the weighted record shaping selector: it watches the item, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on wrss_pkg for the item layouts, request codes and register indexes.
module wrss_shaping_checker
  import wrss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [S_TDATA_W-1:0]   s_axis_tdata,
  input  logic [S_TUSER_W-1:0]   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [M_TDATA_W-1:0]   m_axis_tdata,
  input  logic [M_TUSER_W-1:0]   m_axis_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding,
  output int                     results_checked,
  output int                     outcome_hits
);

  localparam int REPORT_CAP = 40;

  // Shadow copy of the outcome table.
  logic [6:0]  tbl_weight    [MAX_OUTCOMES];
  logic        tbl_pad_en    [MAX_OUTCOMES];
  logic        tbl_dly_en    [MAX_OUTCOMES];
  logic [6:0]  tbl_chance    [MAX_OUTCOMES];
  logic [63:0] tbl_pad_range [MAX_OUTCOMES];
  logic [63:0] tbl_dly_range [MAX_OUTCOMES];

  // Shadow counters and settings.
  logic [31:0] cnt_seen, cnt_delayed, cnt_padded;
  logic [47:0] tot_requested, tot_effective;
  logic        set_enable;
  logic [31:0] set_limit;
  logic [3:0]  set_count;

  result_t expected_results[$];
  int      fail_total = 0;
  int      checked_total = 0;
  int      hit_total = 0;

  // A draw below the minimum gives the minimum; otherwise a draw above the
  // maximum gives the maximum. This order also settles inverted ranges.
  function automatic logic [31:0] clamp_draw(logic [31:0] draw, logic [63:0] bounds);
    if (draw < bounds[31:0]) return bounds[31:0];
    if (draw > bounds[63:32]) return bounds[63:32];
    return draw;
  endfunction

  // Works out the result of one request and advances the shadow state.
  task automatic shape_request(input item_t req, output result_t res);
    int unsigned walk_len;
    int unsigned weight_sum;
    bit          found;
    logic [31:0] pad;
    logic [31:0] dly;
    res = '0;
    weight_sum = 0;
    found = 1'b0;
    if (req.req_type == REQ_DECIDE) begin
      if (set_enable && req.pick_pct >= 7'd1 && req.pick_pct <= 7'(PCT_MAX) &&
          req.dly_pct >= 7'd1 && req.dly_pct <= 7'(PCT_MAX)) begin
        res.accepted = 1'b1;
        // Records past the leading window are accepted but left alone.
        if (cnt_seen < set_limit) begin
          cnt_seen = cnt_seen + 32'd1;
          res.considered = 1'b1;
          walk_len = (int'(set_count) > MAX_OUTCOMES) ? MAX_OUTCOMES : int'(set_count);
          for (int i = 0; i < MAX_OUTCOMES; i++) begin
            if (i < walk_len && !found) begin
              weight_sum += 32'(tbl_weight[i]);
              if (32'(req.pick_pct) <= weight_sum) begin
                found = 1'b1;
                pad = '0;
                dly = '0;
                if (tbl_pad_en[i])
                  pad = clamp_draw(req.pad_raw, tbl_pad_range[i]);
                if (tbl_dly_en[i] && req.dly_pct <= tbl_chance[i])
                  dly = clamp_draw(req.dly_raw, tbl_dly_range[i]);
                if (dly != 32'd0)
                  cnt_delayed = cnt_delayed + 32'd1;
                res.entry_hit         = 1'b1;
                res.entry_sel         = i[2:0];
                res.padding_bytes_out = pad;
                res.delay_ms_out      = dly;
              end
            end
          end
        end
      end
    end else if (req.req_type == REQ_STATS) begin
      // Statistics ignore the enable; a zero request changes nothing.
      res.accepted = 1'b1;
      if (req.requested_padding != 32'd0) begin
        if (req.effective_padding != 32'd0)
          cnt_padded = cnt_padded + 32'd1;
        tot_requested = tot_requested + 48'(req.requested_padding);
        tot_effective = tot_effective + 48'(req.effective_padding);
      end
    end else if (req.req_type == REQ_WEIGHT) begin
      res.accepted = 1'b1;
      tbl_weight[req.entry_index] = req.entry_weight;
      tbl_pad_en[req.entry_index] = req.entry_enables[0];
      tbl_dly_en[req.entry_index] = req.entry_enables[1];
      tbl_chance[req.entry_index] = req.entry_delay_chance;
    end else if (req.req_type == REQ_PAD_RANGE) begin
      res.accepted = 1'b1;
      tbl_pad_range[req.entry_index] = req.range_bounds;
    end else if (req.req_type == REQ_DLY_RANGE) begin
      res.accepted = 1'b1;
      tbl_dly_range[req.entry_index] = req.range_bounds;
    end
    res.records_seen_count    = cnt_seen;
    res.records_delayed_count = cnt_delayed;
    res.records_padded_count  = cnt_padded;
    res.requested_bytes_total = tot_requested;
    res.effective_bytes_total = tot_effective;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_total++;
      if (fail_total <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_result(result_t want, result_t got);
    check_field("accepted", 64'(want.accepted), 64'(got.accepted));
    check_field("considered", 64'(want.considered), 64'(got.considered));
    check_field("entry_hit", 64'(want.entry_hit), 64'(got.entry_hit));
    check_field("entry_sel", 64'(want.entry_sel), 64'(got.entry_sel));
    check_field("padding_bytes_out", 64'(want.padding_bytes_out),
                64'(got.padding_bytes_out));
    check_field("delay_ms_out", 64'(want.delay_ms_out), 64'(got.delay_ms_out));
    check_field("records_seen_count", 64'(want.records_seen_count),
                64'(got.records_seen_count));
    check_field("records_delayed_count", 64'(want.records_delayed_count),
                64'(got.records_delayed_count));
    check_field("records_padded_count", 64'(want.records_padded_count),
                64'(got.records_padded_count));
    check_field("requested_bytes_total", 64'(want.requested_bytes_total),
                64'(got.requested_bytes_total));
    check_field("effective_bytes_total", 64'(want.effective_bytes_total),
                64'(got.effective_bytes_total));
  endtask

  // Everything is sampled at the rising edge, before the edge's updates land.
  always @(posedge clk) begin : monitor
    item_t   req;
    result_t want;
    result_t got;
    if (rst) begin
      for (int i = 0; i < MAX_OUTCOMES; i++) begin
        tbl_weight[i]    = '0;
        tbl_pad_en[i]    = 1'b0;
        tbl_dly_en[i]    = 1'b0;
        tbl_chance[i]    = '0;
        tbl_pad_range[i] = '0;
        tbl_dly_range[i] = '0;
      end
      cnt_seen      = '0;
      cnt_delayed   = '0;
      cnt_padded    = '0;
      tot_requested = '0;
      tot_effective = '0;
      set_enable    = 1'b0;
      set_limit     = '0;
      set_count     = '0;
      expected_results.delete();
    end else begin
      // Register writes arrive only while the block is idle.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENABLE: set_enable = cfg_data[0];
          CFG_LIMIT:  set_limit  = cfg_data;
          CFG_COUNT:  set_count  = cfg_data[3:0];
          default: ;
        endcase
      end

      // Each result item is matched against the oldest expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        {got.effective_bytes_total, got.requested_bytes_total, got.records_padded_count,
         got.records_delayed_count, got.records_seen_count, got.delay_ms_out,
         got.padding_bytes_out, got.entry_sel, got.entry_hit,
         got.considered} = m_axis_tdata[260:0];
        got.accepted = m_axis_tuser[0];
        if (expected_results.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_CAP)
            $display("%0t: result item with nothing expected, actual %0h", $time, got);
        end else begin
          want = expected_results.pop_front();
          compare_result(want, got);
          checked_total++;
        end
      end

      // Each accepted input item queues one expected result.
      if (s_axis_tvalid && s_axis_tready) begin
        {req.range_bounds, req.entry_delay_chance, req.entry_enables, req.entry_weight,
         req.entry_index, req.effective_padding, req.requested_padding, req.dly_raw,
         req.pad_raw, req.dly_pct, req.pick_pct} = s_axis_tdata[224:0];
        req.req_type = s_axis_tuser;
        shape_request(req, want);
        if (want.entry_hit)
          hit_total++;
        expected_results.push_back(want);
      end
    end
    mismatches      <= fail_total;
    outstanding     <= expected_results.size();
    results_checked <= checked_total;
    outcome_hits    <= hit_total;
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the weighted record shaping selector testbench: clock, reset, stimulus,
// result stalls and the verdict. Depends on wrss_pkg, wrss_shaping_checker and the block.
module tb_top;
  import wrss_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 112;
  localparam int RANDOM_PHASES = 6;
  localparam int TAIL_CYCLES  = 20;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic [M_TUSER_W-1:0]   m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int outstanding;
  int results_checked;
  int outcome_hits;

  int unsigned burst_left = 0;
  bit          steady = 1'b0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 1;

  always #1 clk = ~clk;

  weighted_record_shaping_selector uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  wrss_shaping_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .outcome_hits    (outcome_hits)
  );

  // Raw draw: full range, values up to 2500, the extremes, or values up to 600.
  function automatic logic [31:0] random_draw();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 2500);
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom_range(0, 600);
    endcase
  endfunction

  // One random request; fields the request does not use are random as well.
  function automatic item_t random_request();
    item_t       req;
    int unsigned pick;
    logic [31:0] lo, hi;
    pick = $urandom_range(0, 99);
    if (pick < 50)      req.req_type = REQ_DECIDE;
    else if (pick < 65) req.req_type = REQ_STATS;
    else if (pick < 80) req.req_type = REQ_WEIGHT;
    else if (pick < 88) req.req_type = REQ_PAD_RANGE;
    else if (pick < 96) req.req_type = REQ_DLY_RANGE;
    else                req.req_type = REQ_DLY_RANGE + 3'($urandom_range(1, 3));
    // Rolls are mostly in range, with an occasional bad one.
    req.pick_pct = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(1, PCT_MAX));
    req.dly_pct  = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(1, PCT_MAX));
    req.pad_raw  = random_draw();
    req.dly_raw  = random_draw();
    req.requested_padding = ($urandom_range(0, 7) == 0) ? 32'h0 : random_draw();
    req.effective_padding = ($urandom_range(0, 3) == 0) ? 32'h0 : random_draw();
    req.entry_index  = 3'($urandom_range(0, MAX_OUTCOMES - 1));
    // Small weights keep the running sum near the roll range.
    req.entry_weight = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 35));
    req.entry_enables = 2'($urandom_range(0, 3));
    req.entry_delay_chance = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                         : 7'($urandom_range(0, PCT_MAX));
    lo = $urandom_range(0, 500);
    hi = lo + $urandom_range(0, 2000);
    case ($urandom_range(0, 5))
      0:       req.range_bounds = {lo, hi};
      1:       req.range_bounds = {$urandom, $urandom};
      default: req.range_bounds = {hi, lo};
    endcase
    return req;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_request(item_t req);
    logic [S_TDATA_W-1:0] word;
    word = '0;
    word[224:0] = {req.range_bounds, req.entry_delay_chance, req.entry_enables,
                   req.entry_weight, req.entry_index, req.effective_padding,
                   req.requested_padding, req.dly_raw, req.pad_raw,
                   req.dly_pct, req.pick_pct};
    return word;
  endfunction

  // Offers one item in the current burst, opening a new burst, sometimes after a gap, when the old one ends.
  task automatic send_request(input item_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.req_type;
    s_axis_tdata  <= pack_request(req);
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_decide(logic [6:0] oroll, logic [6:0] droll,
                             logic [31:0] pdraw, logic [31:0] ddraw);
    item_t req;
    req = random_request();
    req.req_type = REQ_DECIDE;
    req.pick_pct = oroll;
    req.dly_pct  = droll;
    req.pad_raw  = pdraw;
    req.dly_raw  = ddraw;
    send_request(req);
  endtask

  task automatic send_stats(logic [31:0] requested, logic [31:0] effective);
    item_t req;
    req = random_request();
    req.req_type          = REQ_STATS;
    req.requested_padding = requested;
    req.effective_padding = effective;
    send_request(req);
  endtask

  task automatic send_weight(logic [2:0] idx, logic [6:0] weight, logic [1:0] enables,
                             logic [6:0] chance);
    item_t req;
    req = random_request();
    req.req_type           = REQ_WEIGHT;
    req.entry_index        = idx;
    req.entry_weight       = weight;
    req.entry_enables      = enables;
    req.entry_delay_chance = chance;
    send_request(req);
  endtask

  task automatic send_range(logic [2:0] code, logic [2:0] idx, logic [31:0] lo,
                            logic [31:0] hi);
    item_t req;
    req = random_request();
    req.req_type     = code;
    req.entry_index  = idx;
    req.range_bounds = {hi, lo};
    send_request(req);
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drains the block, then writes all three registers.
  task automatic program_settings(logic enable, logic [31:0] limit, logic [3:0] count);
    drain_results();
    write_register(CFG_ENABLE, {31'b0, enable});
    write_register(CFG_LIMIT, limit);
    write_register(CFG_COUNT, {28'b0, count});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Result side: stall patterns take turns, picked by bits 8:6 of the cycle counter, with one long hold-off
  // that lets the block fill up while the sender keeps offering items.
  int unsigned rx_cycle;
  int unsigned rx_taken;
  int unsigned rx_hold;
  bit          rx_held;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_cycle      <= 0;
      rx_taken      <= 0;
      rx_hold       <= 0;
      rx_held       <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (m_axis_tvalid && m_axis_tready)
        rx_taken <= rx_taken + 1;
      if (rx_hold != 0) begin
        rx_hold       <= rx_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (!rx_held && rx_taken >= HOLD_AFTER) begin
        rx_held       <= 1'b1;
        rx_hold       <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_cycle[8:6])
          3'd0, 3'd1: m_axis_tready <= 1'b1;
          3'd2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          3'd3:       m_axis_tready <= (rx_cycle[1:0] != 2'd0);
          3'd4:       m_axis_tready <= ($urandom_range(0, 1) == 1);
          3'd5:       m_axis_tready <= rx_cycle[3];
          default:    m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Ends the run when no item moves on any channel for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("weighted_record_shaping_selector regression: fail");
    $finish;
  end

  initial begin : stimulus
    item_t       req;
    logic        enable;
    logic [31:0] limit;
    logic [3:0]  count;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: decides are rejected, statistics still count.
    send_decide(7'd50, 7'd50, 32'd10, 32'd10);
    send_stats(32'h0, 32'd7);
    send_stats(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_stats(32'd3, 32'h0);
    req = random_request();
    req.req_type = REQ_DLY_RANGE + 3'd1;
    send_request(req);
    req.req_type = REQ_DLY_RANGE + 3'd3;
    send_request(req);

    // Table load, including an oversized weight and chance and an inverted range.
    send_weight(3'd0, 7'd30, 2'b11, 7'd100);
    send_weight(3'd1, 7'd20, 2'b01, 7'd0);
    send_weight(3'd2, 7'd50, 2'b10, 7'd50);
    send_weight(3'd7, 7'd127, 2'b11, 7'd127);
    send_range(REQ_PAD_RANGE, 3'd0, 32'd100, 32'd200);
    send_range(REQ_PAD_RANGE, 3'd1, 32'd500, 32'd10);
    send_range(REQ_DLY_RANGE, 3'd0, 32'h0, 32'hFFFF_FFFF);
    send_range(REQ_DLY_RANGE, 3'd2, 32'd5, 32'd9);

    // Enabled with an oversized entry count: roll edges, clamps and bad rolls.
    program_settings(1'b1, 32'hFFFF_FFFF, 4'd15);
    send_decide(7'd1, 7'd1, 32'h0, 32'hFFFF_FFFF);
    send_decide(7'd30, 7'd100, 32'hFFFF_FFFF, 32'h0);
    send_decide(7'd31, 7'd50, 32'd300, 32'd40);
    send_decide(7'd50, 7'd50, 32'd600, 32'd40);
    send_decide(7'd100, 7'd50, 32'd77, 32'd7);
    send_decide(7'd100, 7'd51, 32'd77, 32'd7);
    send_decide(7'd0, 7'd50, 32'd1, 32'd1);
    send_decide(7'd101, 7'd50, 32'd1, 32'd1);
    send_decide(7'd50, 7'd0, 32'd1, 32'd1);
    send_decide(7'd50, 7'd127, 32'd1, 32'd1);

    // Window already passed, then rolls beyond every entry in use.
    program_settings(1'b1, 32'h0, 4'd8);
    send_decide(7'd10, 7'd10, 32'd150, 32'd3);
    program_settings(1'b1, 32'hFFFF_FFFF, 4'd2);
    send_decide(7'd80, 7'd10, 32'd150, 32'd3);
    program_settings(1'b1, 32'hFFFF_FFFF, 4'd0);
    send_decide(7'd1, 7'd10, 32'd150, 32'd3);

    // Random phases, each under its own settings.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      enable = 1'b1;
      limit  = 32'hFFFF_FFFF;
      count  = 4'd8;
      case (phase)
        1: begin
          limit = $urandom;
          count = 4'($urandom_range(1, 7));
        end
        2: enable = 1'b0;
        3: begin
          limit = $urandom_range(0, 900);
          count = 4'd15;
        end
        4: count = 4'($urandom_range(0, 15));
        default: ;
      endcase
      program_settings(enable, limit, count);
      steady = (phase == 4);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_request(random_request());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d request items under %0d register settings; %0d results checked.",
             items_sent, settings_used, results_checked);
    $display("%0d decisions selected a table entry; %0d mismatches.",
             outcome_hits, mismatches);
    if (mismatches == 0)
      $display("weighted_record_shaping_selector regression: pass");
    else
      $display("weighted_record_shaping_selector regression: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/wrss_pkg.sv
rtl/wrss_ctrl.sv
rtl/wrss_datapath.sv
rtl/weighted_record_shaping_selector.sv
rtl/wrss_checker.sv
tb/sv/wrss_shaping_checker.sv
tb/sv/tb_top.sv
